// ===== rtl/periodic_timer_table_macros.svh =====
// Assertion macros for the timer table RTL.
// Depends on nothing; included by periodic_timer_table, which carries the checks.
`ifndef PERIODIC_TIMER_TABLE_MACROS_SVH
`define PERIODIC_TIMER_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define PTT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("periodic_timer_table: same-cycle check failed");

// Next-cycle implication, disabled while reset is low
`define PTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("periodic_timer_table: next-cycle check failed");

`endif

// ===== rtl/ptt_pkg.sv =====
// Shared types and codes for the periodic timer table.
// No dependencies; imported by ptt_cell, periodic_timer_table and the testbench.
package ptt_pkg;

    // Request codes
    localparam logic [2:0] REQ_TICK   = 3'd0;
    localparam logic [2:0] REQ_ADD    = 3'd1;
    localparam logic [2:0] REQ_DELETE = 3'd2;
    localparam logic [2:0] REQ_CHANGE = 3'd3;
    localparam logic [2:0] REQ_GET    = 3'd4;
    localparam logic [2:0] REQ_CLEAR  = 3'd5;

    // Result kinds
    localparam logic [2:0] KIND_OK        = 3'd0;
    localparam logic [2:0] KIND_NOT_FOUND = 3'd1;
    localparam logic [2:0] KIND_FIRED     = 3'd2;
    localparam logic [2:0] KIND_DONE      = 3'd3;
    localparam logic [2:0] KIND_REJECTED  = 3'd4;
    localparam logic [2:0] KIND_READ      = 3'd5;

    // One timer slot
    typedef struct packed {
        logic [15:0]        id;
        logic signed [31:0] param;
        logic [31:0]        interval;
        logic [31:0]        last_fire;
        logic               marked;
    } t_slot;

    // Per-cell control: shift toward the head, and/or load the pushed slot
    typedef struct packed {
        logic shift;
        logic take_push;
    } t_cell_ctl;

    // One result item
    typedef struct packed {
        logic [2:0]         kind;
        logic [15:0]        out_id;
        logic signed [31:0] out_param;
        logic [31:0]        out_interval;
        logic               last;
    } t_rsp;

endpackage

// ===== rtl/ptt_req_if.sv =====
// Request channel: valid/ready handshake with the request fields.
// Depends on nothing.
interface ptt_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         req_type;
    logic [31:0]        now_ms;
    logic [15:0]        timer_id;
    logic [31:0]        interval_ms;
    logic signed [31:0] user_param;

    modport source (output valid, req_type, now_ms, timer_id, interval_ms, user_param,
                    input ready);
    modport sink   (input valid, req_type, now_ms, timer_id, interval_ms, user_param,
                    output ready);
endinterface

// ===== rtl/ptt_rsp_if.sv =====
// Result channel: valid/ready handshake with the result fields.
// Depends on nothing.
interface ptt_rsp_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic [15:0]        out_id;
    logic signed [31:0] out_param;
    logic [31:0]        out_interval;
    logic               last;

    modport source (output valid, kind, out_id, out_param, out_interval, last,
                    input ready);
    modport sink   (input valid, kind, out_id, out_param, out_interval, last,
                    output ready);
endinterface

// ===== rtl/ptt_cell.sv =====
// One slot cell of the timer chain: holds a slot, takes its neighbor's
// slot on a shift, or the pushed slot when selected. Uses ptt_pkg.
module ptt_cell
    import ptt_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_slot     i_next,
    input  t_slot     i_push,
    output t_slot     o_slot
);

    t_slot r_slot;
    t_slot n_slot;

    // Load selection: pushed slot wins, else neighbor on shift, else hold
    always_comb begin
        n_slot = r_slot;
        if (i_ctl.take_push) begin
            n_slot = i_push;
        end else if (i_ctl.shift) begin
            n_slot = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_slot = r_slot;

endmodule

// ===== rtl/periodic_timer_table.sv =====
// Top level of the periodic timer table: a chain of slot cells with a
// head processor and a registered result stage. Uses ptt_pkg, the two
// channel interfaces and periodic_timer_table_macros.svh.
//
// Usage:
//   i_req carries one request item (tick, add, delete, change, get, clear)
//   with the current millisecond time. o_rsp returns the result items; the
//   final one of each request has last = 1. A tick returns one item per due
//   timer in table order and then a done item.
//   Flow: add, unknown codes and any other request on an empty table go
//   from accept straight to the final state, which registers the final
//   result. Tick, delete, change, get and clear first rotate every stored
//   slot once through the head of the cell chain, one slot per cycle unless
//   a fired item waits on a stalled output. The single head port sets that rate.
//   A new request is taken once the previous one has produced its last
//   item into the output register, even while that item still waits.
//   Reset empties the table (entry count zero) and drops any pending item.
//   When the receiver stalls, the output register holds its item and the
//   scan pauses at the next slot that needs to emit a fired item.
`include "periodic_timer_table_macros.svh"

module periodic_timer_table
    import ptt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ptt_req_if.sink    i_req,
    ptt_rsp_if.source  o_rsp
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_left,  n_left;
    logic               r_found, n_found;
    logic [31:0]        r_get_ival, n_get_ival;
    logic [2:0]         r_req;
    logic [31:0]        r_now;
    logic [15:0]        r_id;
    logic [31:0]        r_ival;
    logic signed [31:0] r_param;
    t_rsp               r_out, n_out;
    logic               r_out_valid, n_out_valid;

    t_slot              w_slot [TABLE_DEPTH];
    t_cell_ctl          w_ctl  [TABLE_DEPTH];
    t_slot              w_push;
    t_slot              w_head;
    logic               w_shift;
    logic               w_push_en;
    logic [CW-1:0]      w_wr_pos;
    logic               w_out_free;
    logic               w_emit;
    logic               w_step_ok;
    logic               w_fire;
    logic               w_match;
    logic               w_accept;
    logic               w_full;
    logic [31:0]        w_elapsed;

    assign w_head     = w_slot[0];
    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign w_accept   = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign w_full     = (r_count >= CW'(TABLE_DEPTH));

    // Head evaluation
    assign w_elapsed = r_now - w_head.last_fire;
    assign w_fire    = !w_head.marked && (w_elapsed >= w_head.interval);
    assign w_match   = !r_found && (w_head.id == r_id);

    // Scan steps stall only when a fired item must be emitted
    assign w_step_ok = !((r_req == REQ_TICK) && w_fire) || w_out_free;

    // Request capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req   <= i_req.req_type;
            r_now   <= i_req.now_ms;
            r_id    <= i_req.timer_id;
            r_ival  <= i_req.interval_ms;
            r_param <= i_req.user_param;
        end
    end

    // Sequencer and head processing
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_left      = r_left;
        n_found     = r_found;
        n_get_ival  = r_get_ival;
        n_out       = r_out;
        w_emit      = 1'b0;
        w_shift     = 1'b0;
        w_push_en   = 1'b0;
        w_push      = w_head;
        w_wr_pos    = r_count - 1'b1;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_left  = r_count;
                    n_found = 1'b0;
                    if ((i_req.req_type == REQ_TICK || i_req.req_type == REQ_DELETE ||
                         i_req.req_type == REQ_CHANGE || i_req.req_type == REQ_GET ||
                         i_req.req_type == REQ_CLEAR) && r_count != '0) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_SCAN: begin
                if (w_step_ok) begin
                    w_shift   = 1'b1;
                    w_push_en = 1'b1;
                    n_left    = r_left - 1'b1;
                    case (r_req)
                        REQ_TICK: begin
                            if (w_head.marked) begin
                                w_push_en = 1'b0;
                                n_count   = r_count - 1'b1;
                            end else if (w_fire) begin
                                w_push.last_fire = r_now;
                                w_emit           = 1'b1;
                                n_out.kind         = KIND_FIRED;
                                n_out.out_id       = w_head.id;
                                n_out.out_param    = w_head.param;
                                n_out.out_interval = w_head.interval;
                                n_out.last         = 1'b0;
                            end
                        end
                        REQ_DELETE: begin
                            if (w_match) begin
                                w_push.marked = 1'b1;
                                n_found       = 1'b1;
                            end
                        end
                        REQ_CHANGE: begin
                            if (w_match) begin
                                w_push.interval = r_ival;
                                n_found         = 1'b1;
                            end
                        end
                        REQ_GET: begin
                            if (w_match) begin
                                n_get_ival = w_head.interval;
                                n_found    = 1'b1;
                            end
                        end
                        REQ_CLEAR: begin
                            w_push.marked = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                    if (r_left == CW'(1)) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    w_emit             = 1'b1;
                    n_state            = S_IDLE;
                    n_out.kind         = KIND_OK;
                    n_out.out_id       = r_id;
                    n_out.out_param    = '0;
                    n_out.out_interval = '0;
                    n_out.last         = 1'b1;
                    case (r_req)
                        REQ_TICK: begin
                            n_out.kind   = KIND_DONE;
                            n_out.out_id = '0;
                        end
                        REQ_ADD: begin
                            if (r_ival == '0 || w_full) begin
                                n_out.kind = KIND_REJECTED;
                            end else begin
                                w_push_en        = 1'b1;
                                w_wr_pos         = r_count;
                                w_push.id        = r_id;
                                w_push.param     = r_param;
                                w_push.interval  = r_ival;
                                w_push.last_fire = r_now;
                                w_push.marked    = 1'b0;
                                n_count          = r_count + 1'b1;
                            end
                        end
                        REQ_DELETE, REQ_CHANGE: begin
                            if (!r_found) begin
                                n_out.kind = KIND_NOT_FOUND;
                            end
                        end
                        REQ_GET: begin
                            if (r_found) begin
                                n_out.kind         = KIND_READ;
                                n_out.out_interval = r_get_ival;
                            end else begin
                                n_out.kind = KIND_NOT_FOUND;
                            end
                        end
                        default: begin
                            n_out.out_id = '0;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = w_emit ? 1'b1 : (o_rsp.ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left     <= n_left;
        r_found    <= n_found;
        r_get_ival <= n_get_ival;
        r_out      <= n_out;
    end

    // Cell chain: cell k takes cell k+1 on a shift; the tail takes the push
    genvar k;
    generate
        for (k = 0; k < TABLE_DEPTH; k++) begin : g_cell
            t_slot w_next;
            assign w_ctl[k].shift     = w_shift;
            assign w_ctl[k].take_push = w_push_en && (w_wr_pos == CW'(k));
            if (k == TABLE_DEPTH - 1) begin : g_tail
                assign w_next = w_push;
            end else begin : g_mid
                assign w_next = w_slot[k+1];
            end
            ptt_cell u_cell (
                .i_clk  (i_clk),
                .i_ctl  (w_ctl[k]),
                .i_next (w_next),
                .i_push (w_push),
                .o_slot (w_slot[k])
            );
        end
    endgenerate

    // Result port
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.kind         = r_out.kind;
    assign o_rsp.out_id       = r_out.out_id;
    assign o_rsp.out_param    = r_out.out_param;
    assign o_rsp.out_interval = r_out.out_interval;
    assign o_rsp.last         = r_out.last;

    // Checks
    `PTT_ASSERT_NOW(a_count_in_range, i_clk, i_rst_n, 1'b1, r_count <= CW'(TABLE_DEPTH))
    `PTT_ASSERT_NOW(a_scan_left_ok, i_clk, i_rst_n, r_state == S_SCAN,
        r_left != '0 && r_left <= r_count)
    `PTT_ASSERT_NEXT(a_fin_to_idle, i_clk, i_rst_n, r_state == S_FIN && w_out_free,
        r_state == S_IDLE && r_out_valid && r_out.last)
    `PTT_ASSERT_NEXT(a_drop_shrinks, i_clk, i_rst_n,
        r_state == S_SCAN && w_step_ok && r_req == REQ_TICK && w_head.marked,
        r_count + 1'b1 == $past(r_count))
    `PTT_ASSERT_NOW(a_emit_needs_room, i_clk, i_rst_n, w_emit, w_out_free)

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for periodic_timer_table: directed and random timer requests,
// with every result item checked against an in-bench model of the timer table.
// Depends on ptt_pkg, ptt_req_if, ptt_rsp_if and the periodic_timer_table RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ptt_pkg::*;

    localparam int DEPTH        = 16;
    localparam int IDLE_PCT     = 31;
    localparam int RANDOM_ITEMS = 480;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = DEPTH + 8;

    // Request codes with no defined operation
    localparam logic [2:0] REQ_UNDEF_A = 3'd6;
    localparam logic [2:0] REQ_UNDEF_B = 3'd7;

    typedef struct {
        logic [2:0]         req_type;
        logic [31:0]        now_ms;
        logic [15:0]        timer_id;
        logic [31:0]        interval_ms;
        logic signed [31:0] user_param;
        bit                 drain;   // hold off until all results are back
        bit                 steady;  // no gaps on either side
    } t_timer_req;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ptt_req_if req_ch ();
    ptt_rsp_if rsp_ch ();

    periodic_timer_table #(.TABLE_DEPTH(DEPTH)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always #5 i_clk = ~i_clk;

    t_timer_req  req_backlog[$];
    t_rsp        awaited_rsp[$];
    t_slot       slots[DEPTH];
    int          slot_count = 0;
    logic [31:0] clock_ms = 32'hFFFF_FFC0;
    t_timer_req  drv_item;
    bit          steady_now = 1'b0;
    int          n_queued = 0;
    int          n_accepted = 0;
    int          n_results = 0;
    int          n_errors = 0;
    int          n_fired = 0;
    int          n_rejected = 0;
    int          n_missed = 0;
    int          n_reads = 0;
    int          cycle_count = 0;

    function automatic void await_rsp(logic [2:0] kind, logic [15:0] id, logic [31:0] param,
                                      logic [31:0] interval, logic last);
        t_rsp r;
        r.kind         = kind;
        r.out_id       = id;
        r.out_param    = param;
        r.out_interval = interval;
        r.last         = last;
        awaited_rsp    = {awaited_rsp, r};
    endfunction

    // First slot holding the id, marked or not; -1 when absent
    function automatic int first_slot(logic [15:0] id);
        for (int i = 0; i < slot_count; i++) begin
            if (slots[i].id == id) return i;
        end
        return -1;
    endfunction

    // Update the table for one accepted request and queue the results it causes
    function automatic void timer_table_apply(t_timer_req r);
        int          hit;
        int          w;
        logic [31:0] elapsed;
        hit = first_slot(r.timer_id);
        case (r.req_type)
            REQ_TICK: begin
                // drop marked slots, keeping order
                w = 0;
                for (int i = 0; i < slot_count; i++) begin
                    if (!slots[i].marked) begin
                        slots[w] = slots[i];
                        slots[w].marked = 1'b0;
                        w++;
                    end
                end
                slot_count = w;
                // fire due timers; elapsed time wraps modulo 2^32
                for (int i = 0; i < slot_count; i++) begin
                    elapsed = r.now_ms - slots[i].last_fire;
                    if (elapsed >= slots[i].interval) begin
                        slots[i].last_fire = r.now_ms;
                        await_rsp(KIND_FIRED, slots[i].id, slots[i].param,
                                  slots[i].interval, 1'b0);
                    end
                end
                await_rsp(KIND_DONE, '0, '0, '0, 1'b1);
            end
            REQ_ADD: begin
                if (r.interval_ms == '0 || slot_count >= DEPTH) begin
                    await_rsp(KIND_REJECTED, r.timer_id, '0, '0, 1'b1);
                end else begin
                    slots[slot_count].id        = r.timer_id;
                    slots[slot_count].param     = r.user_param;
                    slots[slot_count].interval  = r.interval_ms;
                    slots[slot_count].last_fire = r.now_ms;
                    slots[slot_count].marked    = 1'b0;
                    slot_count++;
                    await_rsp(KIND_OK, r.timer_id, '0, '0, 1'b1);
                end
            end
            REQ_DELETE, REQ_CHANGE, REQ_GET: begin
                if (hit < 0) begin
                    await_rsp(KIND_NOT_FOUND, r.timer_id, '0, '0, 1'b1);
                end else if (r.req_type == REQ_DELETE) begin
                    slots[hit].marked = 1'b1;
                    await_rsp(KIND_OK, r.timer_id, '0, '0, 1'b1);
                end else if (r.req_type == REQ_CHANGE) begin
                    slots[hit].interval = r.interval_ms;
                    await_rsp(KIND_OK, r.timer_id, '0, '0, 1'b1);
                end else begin
                    await_rsp(KIND_READ, r.timer_id, '0, slots[hit].interval, 1'b1);
                end
            end
            REQ_CLEAR: begin
                for (int i = 0; i < slot_count; i++) slots[i].marked = 1'b1;
                await_rsp(KIND_OK, '0, '0, '0, 1'b1);
            end
            default: begin
                await_rsp(KIND_OK, '0, '0, '0, 1'b1);
            end
        endcase
    endfunction

    // Append a request; the millisecond clock advances by step first
    function automatic void queue_req(logic [2:0] kind, logic [15:0] id, logic [31:0] interval,
                                      logic [31:0] param, logic [31:0] step);
        t_timer_req r;
        clock_ms      = clock_ms + step;
        r.req_type    = kind;
        r.now_ms      = clock_ms;
        r.timer_id    = id;
        r.interval_ms = interval;
        r.user_param  = param;
        r.drain       = 1'b0;
        r.steady      = 1'b0;
        req_backlog   = {req_backlog, r};
        n_queued++;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    // Request driver: presents the backlog with random gaps
    always @(posedge i_clk) begin : drive_req
        bit go;
        if (!i_rst_n) begin
            req_ch.valid       <= 1'b0;
            req_ch.req_type    <= REQ_TICK;
            req_ch.now_ms      <= '0;
            req_ch.timer_id    <= '0;
            req_ch.interval_ms <= '0;
            req_ch.user_param  <= '0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                timer_table_apply(drv_item);
                n_accepted++;
            end
            if (!req_ch.valid || req_ch.ready) begin
                go = 1'b0;
                if (req_backlog.size() != 0 &&
                    !(req_backlog[0].drain && awaited_rsp.size() != 0)) begin
                    go = req_backlog[0].steady || ($urandom_range(0, 99) >= IDLE_PCT);
                end
                if (go) begin
                    drv_item = req_backlog.pop_front();
                    req_ch.req_type    <= drv_item.req_type;
                    req_ch.now_ms      <= drv_item.now_ms;
                    req_ch.timer_id    <= drv_item.timer_id;
                    req_ch.interval_ms <= drv_item.interval_ms;
                    req_ch.user_param  <= drv_item.user_param;
                    steady_now         <= drv_item.steady;
                end
                req_ch.valid <= go;
            end
        end
    end

    // Result monitor: random stalls, each item checked against the oldest expectation
    always @(posedge i_clk) begin : watch_rsp
        t_rsp want;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                n_results++;
                if (awaited_rsp.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result, expected none, got kind %0d id %0h",
                             $time, rsp_ch.kind, rsp_ch.out_id);
                end else begin
                    want = awaited_rsp.pop_front();
                    check_field("kind", 32'(want.kind), 32'(rsp_ch.kind));
                    check_field("out_id", 32'(want.out_id), 32'(rsp_ch.out_id));
                    check_field("out_param", want.out_param, rsp_ch.out_param);
                    check_field("out_interval", want.out_interval, rsp_ch.out_interval);
                    check_field("last", 32'(want.last), 32'(rsp_ch.last));
                    if (want.kind == KIND_FIRED) n_fired++;
                    if (want.kind == KIND_REJECTED) n_rejected++;
                    if (want.kind == KIND_NOT_FOUND) n_missed++;
                    if (want.kind == KIND_READ) n_reads++;
                end
            end
            rsp_ch.ready <= steady_now || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d requests unsent, %0d results awaited",
                     $time, n_queued - n_accepted, awaited_rsp.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Stimulus and end of run
    initial begin
        int          sel;
        int          pick;
        logic [2:0]  kind;
        logic [15:0] id;
        logic [31:0] interval;
        logic [31:0] step;

        // Directed: empty tick, rejects, field extremes, duplicates, marked lookups, wrap
        queue_req(REQ_TICK, 16'h0000, 32'h0, 32'h0, 0);
        queue_req(REQ_ADD, 16'h0005, 32'h0, 32'h1234_5678, 1);
        queue_req(REQ_ADD, 16'h0000, 32'h1, 32'h8000_0000, 1);
        queue_req(REQ_ADD, 16'hFFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1);
        queue_req(REQ_ADD, 16'h0000, 32'h7, 32'hFFFF_FFFF, 1);
        queue_req(REQ_GET, 16'h0000, 32'h0, 32'h0, 1);
        queue_req(REQ_GET, 16'h1234, 32'h0, 32'h0, 1);
        queue_req(REQ_CHANGE, 16'h0000, 32'h0, 32'h0, 1);
        queue_req(REQ_CHANGE, 16'h4321, 32'h9, 32'h0, 1);
        queue_req(REQ_TICK, 16'h0000, 32'h0, 32'h0, 1);
        queue_req(REQ_DELETE, 16'h0000, 32'h0, 32'h0, 1);
        queue_req(REQ_GET, 16'h0000, 32'h0, 32'h0, 1);
        queue_req(REQ_CHANGE, 16'h0000, 32'h2, 32'h0, 1);
        queue_req(REQ_DELETE, 16'h7777, 32'h0, 32'h0, 1);
        queue_req(REQ_TICK, 16'h0000, 32'h0, 32'h0, 100);
        queue_req(REQ_UNDEF_A, 16'hA5A5, 32'hDEAD_BEEF, 32'h5A5A_5A5A, 1);
        queue_req(REQ_UNDEF_B, 16'h5A5A, 32'h1357_9BDF, 32'hA5A5_A5A5, 1);
        queue_req(REQ_CLEAR, 16'h0000, 32'h0, 32'h0, 1);
        queue_req(REQ_ADD, 16'h0003, 32'h2, 32'h0000_0042, 1);
        queue_req(REQ_TICK, 16'h0000, 32'h0, 32'h0, 3);
        queue_req(REQ_CLEAR, 16'h0000, 32'h0, 32'h0, 1);
        queue_req(REQ_TICK, 16'h0000, 32'h0, 32'h0, 5);

        // Fill to capacity and overflow; marked slots still count until a tick
        for (int k = 0; k < DEPTH + 1; k++) begin
            queue_req(REQ_ADD, k[15:0], $urandom_range(1, 40), $urandom, 1);
        end
        queue_req(REQ_DELETE, 16'h0003, 32'h0, 32'h0, 1);
        queue_req(REQ_ADD, 16'h0020, 32'h5, $urandom, 1);
        queue_req(REQ_TICK, 16'h0000, 32'h0, 32'h0, $urandom_range(0, 40));
        queue_req(REQ_ADD, 16'h0021, 32'h5, $urandom, 1);

        // Random mix weighted toward adds and ticks so the table fills and fires often
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            sel      = $urandom_range(0, 99);
            pick     = $urandom_range(0, 99);
            id       = (pick < 10) ? 16'($urandom) : 16'($urandom_range(0, 13));
            interval = (pick < 6) ? 32'h0 : (pick < 12) ? $urandom : $urandom_range(1, 40);
            step     = $urandom_range(0, 3);
            if (sel < 28) begin
                kind = REQ_TICK;
                step = $urandom_range(0, 25);
            end else if (sel < 58) begin
                kind = REQ_ADD;
            end else if (sel < 70) begin
                kind = REQ_DELETE;
            end else if (sel < 78) begin
                kind = REQ_CHANGE;
            end else if (sel < 90) begin
                kind = REQ_GET;
            end else if (sel < 92) begin
                kind = REQ_CLEAR;
            end else if (sel < 96) begin
                kind = (pick[0]) ? REQ_UNDEF_A : REQ_UNDEF_B;
            end else begin
                // noise: any code, any time
                kind     = 3'($urandom_range(0, 7));
                interval = $urandom;
                clock_ms = $urandom;
                step     = 0;
            end
            queue_req(kind, id, interval, $urandom, step);
            if (n % 100 == 99) req_backlog[req_backlog.size() - 1].drain = 1'b1;
            if (n >= 200 && n < 280) req_backlog[req_backlog.size() - 1].steady = 1'b1;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_queued || awaited_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests and checked %0d result items", n_accepted, n_results);
        $display("Seen: %0d firings, %0d rejected adds, %0d missed lookups, %0d reads",
                 n_fired, n_rejected, n_missed, n_reads);
        if (n_errors == 0 && awaited_rsp.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ptt_pkg.sv
rtl/ptt_req_if.sv
rtl/ptt_rsp_if.sv
rtl/ptt_cell.sv
rtl/periodic_timer_table.sv
verif/testbench.sv
